// ===== rtl/core/mtk_pkg.sv =====
package mtk_pkg;

    // Symbol timing and tone shape.
    localparam int unsigned UNIT_SAMPLES   = 2000;
    localparam int unsigned FADE_SAMPLES   = 100;
    localparam int unsigned PERIOD_SAMPLES = 80;
    localparam int unsigned AMPLITUDE      = 3200;

    // pi/2 with 30 fraction bits.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam int unsigned UNITS_W  = 16;
    localparam int unsigned SAMPLE_W = 13;
    localparam int unsigned PHASE_W  = $clog2(PERIOD_SAMPLES);
    localparam int unsigned CNT_W    = $clog2(UNIT_SAMPLES);

    // Tone magnitude, 3200*sin with 16 fraction bits.
    localparam int unsigned MAG_W  = $clog2((AMPLITUDE << 16) + 1);
    // A single ramp factor numerator, and the product of two.
    localparam int unsigned RAMP_W = $clog2(FADE_SAMPLES + 1);
    localparam int unsigned NUM_W  = $clog2(FADE_SAMPLES * FADE_SAMPLES + 1);
    // Scaled magnitude plus rounding offset.
    localparam int unsigned T_W    = MAG_W + NUM_W + 1;
    // Scaled magnitude after dropping the 16 fraction bits.
    localparam int unsigned U_W    =
        $clog2((AMPLITUDE + 1) * FADE_SAMPLES * FADE_SAMPLES + 1);
    localparam int unsigned Q_W    = $clog2(AMPLITUDE + 1);

    // Ramp denominators and their reciprocals with U_W fraction bits.
    localparam logic [U_W-1:0] DEN_ONE_VAL     = U_W'(1);
    localparam logic [U_W-1:0] DEN_FADE_VAL    = U_W'(FADE_SAMPLES);
    localparam logic [U_W-1:0] DEN_FADE_SQ_VAL = U_W'(FADE_SAMPLES * FADE_SAMPLES);

    localparam logic [U_W:0] RECIP_ONE     = (U_W + 1)'(64'd1 << U_W);
    localparam logic [U_W:0] RECIP_FADE    = (U_W + 1)'((64'd1 << U_W) / FADE_SAMPLES);
    localparam logic [U_W:0] RECIP_FADE_SQ =
        (U_W + 1)'((64'd1 << U_W) / (FADE_SAMPLES * FADE_SAMPLES));

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_DIT     = 2'd1,
        ACT_DAH     = 2'd2,
        ACT_SILENCE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        DEN_ONE,
        DEN_FADE,
        DEN_FADE_SQ
    } den_sel_t;

    // Sample request handed from the symbol sequencer to the shaper.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [NUM_W-1:0]   num;
        den_sel_t           den_sel;
        logic               tone;
        logic               active;
        logic               last;
    } tone_req_t;

    // Per-sample flags that ride along the shaper stages.
    typedef struct packed {
        logic neg;
        logic tone;
        logic active;
        logic last;
    } sample_flags_t;

    typedef logic [MAG_W-1:0] mag_table_t [PERIOD_SAMPLES];

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // sin((pi/2) * r / PERIOD_SAMPLES) with 30 fraction bits, Taylor series.
    function automatic logic [63:0] quarter_sine_q30(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (HALF_PI_Q30 * 64'(r) + 64'(PERIOD_SAMPLES / 2)) / 64'(PERIOD_SAMPLES);
        x2   = mul_q30(x, x);
        term = x;
        sum  = longint'(x);
        term = (mul_q30(term, x2) + 64'd3) / 64'd6;
        sum  = sum - longint'(term);
        term = (mul_q30(term, x2) + 64'd10) / 64'd20;
        sum  = sum + longint'(term);
        term = (mul_q30(term, x2) + 64'd21) / 64'd42;
        sum  = sum - longint'(term);
        term = (mul_q30(term, x2) + 64'd36) / 64'd72;
        sum  = sum + longint'(term);
        term = (mul_q30(term, x2) + 64'd55) / 64'd110;
        sum  = sum - longint'(term);
        term = (mul_q30(term, x2) + 64'd78) / 64'd156;
        sum  = sum + longint'(term);
        term = (mul_q30(term, x2) + 64'd105) / 64'd210;
        sum  = sum - longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30))
        begin
            sum = longint'(1) << 30;
        end
        return 64'(sum);
    endfunction

    // Magnitude of one full period, built once at elaboration.
    function automatic mag_table_t build_mag_table();
        mag_table_t  tab;
        int unsigned m;
        int unsigned q;
        int unsigned r;
        logic [63:0] s;
        for (int unsigned p = 0; p < PERIOD_SAMPLES; p++)
        begin
            m = 4 * p;
            q = m / PERIOD_SAMPLES;
            r = m % PERIOD_SAMPLES;
            if (q[0])
            begin
                r = PERIOD_SAMPLES - r;
            end
            s = (quarter_sine_q30(r) * 64'(AMPLITUDE) + (64'd1 << 13)) >> 14;
            tab[p] = MAG_W'(s);
        end
        return tab;
    endfunction

    localparam mag_table_t MAG_TABLE = build_mag_table();

endpackage

// ===== rtl/core/mtk_in_if.sv =====
interface mtk_in_if;
    import mtk_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [UNITS_W-1:0] units;

    modport source (output valid, action, units, input ready);
    modport sink (input valid, action, units, output ready);
endinterface

// ===== rtl/core/mtk_out_if.sv =====
interface mtk_out_if;
    import mtk_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
    logic                       last;

    modport source (output valid, sample, active, last, input ready);
    modport sink (input valid, sample, active, last, output ready);
endinterface

// ===== rtl/core/mtk_seq.sv =====
module mtk_seq (
    input  logic               clk,
    input  logic               rst_n,
    mtk_in_if.sink             cmd,
    input  logic               pipe_ready,
    output logic               req_valid,
    output mtk_pkg::tone_req_t req
);
    import mtk_pkg::*;

    typedef enum logic [1:0] {
        KIND_IDLE,
        KIND_DIT,
        KIND_DAH,
        KIND_SILENCE
    } kind_t;

    kind_t               kind_reg, kind_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [UNITS_W-1:0]  left_reg, left_next;
    logic                req_valid_reg, req_valid_next;
    tone_req_t           req_reg, req_next;

    logic                load;
    logic                accept;
    logic                is_tick;
    logic                fade_in;
    logic                last_unit;
    logic                ramp_up;
    logic                ramp_down;
    logic [RAMP_W-1:0]   ramp_in;
    logic [RAMP_W-1:0]   ramp_out;
    logic [2*RAMP_W-1:0] ramp_both;
    logic                unit_end;

    assign load      = !req_valid_reg || pipe_ready;
    assign cmd.ready = load;
    assign accept    = cmd.valid && load;
    assign is_tick   = (cmd.action == ACT_TICK);

    assign fade_in   = (kind_reg == KIND_DIT) || (kind_reg == KIND_DAH && left_reg == UNITS_W'(3));
    assign last_unit = (left_reg == UNITS_W'(1));
    assign ramp_up   = fade_in && (32'(cnt_reg) < FADE_SAMPLES);
    assign ramp_down = last_unit && (32'(cnt_reg) + FADE_SAMPLES > UNIT_SAMPLES);
    assign ramp_in   = RAMP_W'(cnt_reg);
    assign ramp_out  = RAMP_W'(UNIT_SAMPLES - 32'(cnt_reg));
    assign ramp_both = ramp_in * ramp_out;
    assign unit_end  = (cnt_reg == CNT_W'(UNIT_SAMPLES - 1));

    always_comb
    begin
        kind_next      = kind_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        req_valid_next = req_valid_reg;
        req_next       = req_reg;

        // The request for the current sample: phase, flags and the ramp factor num/den.
        req_next.phase  = phase_reg;
        req_next.tone   = (kind_reg == KIND_DIT) || (kind_reg == KIND_DAH);
        req_next.active = (kind_reg != KIND_IDLE);
        req_next.last   = (kind_reg != KIND_IDLE) && last_unit && unit_end;
        if (ramp_up && ramp_down)
        begin
            req_next.num     = NUM_W'(ramp_both);
            req_next.den_sel = DEN_FADE_SQ;
        end
        else if (ramp_up)
        begin
            req_next.num     = NUM_W'(ramp_in);
            req_next.den_sel = DEN_FADE;
        end
        else if (ramp_down)
        begin
            req_next.num     = NUM_W'(ramp_out);
            req_next.den_sel = DEN_FADE;
        end
        else
        begin
            req_next.num     = NUM_W'(1);
            req_next.den_sel = DEN_ONE;
        end

        if (load)
        begin
            req_valid_next = accept && is_tick;
        end

        if (accept && !is_tick && kind_reg == KIND_IDLE)
        begin
            phase_next = '0;
            cnt_next   = '0;
            case (cmd.action)
                ACT_DIT:
                begin
                    kind_next = KIND_DIT;
                    left_next = UNITS_W'(1);
                end
                ACT_DAH:
                begin
                    kind_next = KIND_DAH;
                    left_next = UNITS_W'(3);
                end
                ACT_SILENCE:
                begin
                    if (cmd.units != '0)
                    begin
                        kind_next = KIND_SILENCE;
                        left_next = cmd.units;
                    end
                end
                default:
                begin
                    kind_next = kind_reg;
                end
            endcase
        end
        else if (accept && is_tick && kind_reg != KIND_IDLE)
        begin
            if (phase_reg == PHASE_W'(PERIOD_SAMPLES - 1))
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_reg + PHASE_W'(1);
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (unit_end)
            begin
                cnt_next   = '0;
                phase_next = '0;
                left_next  = left_reg - UNITS_W'(1);
                if (last_unit)
                begin
                    kind_next = KIND_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_IDLE;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            req_valid_reg <= 1'b0;
            req_reg       <= '0;
        end
        else
        begin
            kind_reg      <= kind_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            req_valid_reg <= req_valid_next;
            if (load)
            begin
                req_reg <= req_next;
            end
        end
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

endmodule

// ===== rtl/core/mtk_shaper.sv =====
module mtk_shaper (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  mtk_pkg::tone_req_t req,
    output logic               pipe_ready,
    mtk_out_if.source          audio
);
    import mtk_pkg::*;

    // Stage A: ramp-scaled magnitude.  Stage B: quotient estimate.
    // Output stage: quotient correction, sign and output register.
    logic                       va_reg, va_next;
    logic                       vb_reg, vb_next;
    logic                       vo_reg, vo_next;
    logic                       en_a, en_b, en_o;

    logic [U_W-1:0]             ua_reg;
    den_sel_t                   da_reg;
    sample_flags_t              fa_reg;
    logic [U_W-1:0]             ub_reg;
    logic [Q_W-1:0]             qb_reg;
    den_sel_t                   db_reg;
    sample_flags_t              fb_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       active_reg;
    logic                       last_reg;

    logic [MAG_W-1:0]           mag;
    logic [U_W-1:0]             round_a;
    logic [T_W-1:0]             scaled;
    sample_flags_t              flags_in;
    logic [U_W:0]               recip;
    logic [2*U_W:0]             qprod;
    logic [U_W-1:0]             den_b;
    logic [U_W-1:0]             back;
    logic [U_W-1:0]             rem;
    logic [Q_W-1:0]             quot;
    logic signed [SAMPLE_W-1:0] mag_s;
    logic signed [SAMPLE_W-1:0] sample_next;

    assign en_o       = !vo_reg || audio.ready;
    assign en_b       = !vb_reg || en_o;
    assign en_a       = !va_reg || en_b;
    assign pipe_ready = en_a;

    assign va_next = en_a ? req_valid : va_reg;
    assign vb_next = en_b ? va_reg : vb_reg;
    assign vo_next = en_o ? vb_reg : vo_reg;

    // Stage A: magnitude times ramp numerator, plus half of den * 2^16.
    always_comb
    begin
        case (req.den_sel)
            DEN_FADE:    round_a = DEN_FADE_VAL;
            DEN_FADE_SQ: round_a = DEN_FADE_SQ_VAL;
            default:     round_a = DEN_ONE_VAL;
        endcase
    end

    assign mag             = MAG_TABLE[req.phase];
    assign scaled          = T_W'(mag) * T_W'(req.num) + (T_W'(round_a) << 15);
    assign flags_in.neg    = (32'(req.phase) * 2 >= PERIOD_SAMPLES);
    assign flags_in.tone   = req.tone;
    assign flags_in.active = req.active;
    assign flags_in.last   = req.last;

    // Stage B: quotient by reciprocal, low by at most one.
    always_comb
    begin
        case (da_reg)
            DEN_FADE:    recip = RECIP_FADE;
            DEN_FADE_SQ: recip = RECIP_FADE_SQ;
            default:     recip = RECIP_ONE;
        endcase
    end

    assign qprod = (2 * U_W + 1)'(ua_reg) * (2 * U_W + 1)'(recip);

    // Output stage: one correction step, then the sign.
    always_comb
    begin
        case (db_reg)
            DEN_FADE:    den_b = DEN_FADE_VAL;
            DEN_FADE_SQ: den_b = DEN_FADE_SQ_VAL;
            default:     den_b = DEN_ONE_VAL;
        endcase
    end

    assign back  = U_W'(U_W'(qb_reg) * den_b);
    assign rem   = ub_reg - back;
    assign quot  = qb_reg + Q_W'(rem >= den_b);
    assign mag_s = SAMPLE_W'(quot);

    always_comb
    begin
        if (!fb_reg.tone)
        begin
            sample_next = '0;
        end
        else if (fb_reg.neg)
        begin
            sample_next = -mag_s;
        end
        else
        begin
            sample_next = mag_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            ua_reg <= U_W'(scaled >> 16);
            da_reg <= req.den_sel;
            fa_reg <= flags_in;
        end
        if (en_b)
        begin
            ub_reg <= ua_reg;
            qb_reg <= Q_W'(qprod >> U_W);
            db_reg <= da_reg;
            fb_reg <= fa_reg;
        end
        if (en_o)
        begin
            sample_reg <= sample_next;
            active_reg <= fb_reg.active;
            last_reg   <= fb_reg.last;
        end
    end

    assign audio.valid  = vo_reg;
    assign audio.sample = sample_reg;
    assign audio.active = active_reg;
    assign audio.last   = last_reg;

endmodule

// ===== rtl/core/morse_tone_keyer.sv =====
// Channel  Role    Payload                       Request moves
// cmd      sink    action, units                 one command: tick or symbol start
// audio    source  sample, active, last          one audio sample, for each tick
//
// A command request is taken in every cycle while the four-stage sample pipe
// has room; a tick's sample moves from the request register through stages A
// and B into the output register on audio. The sequencer's counters set the
// rate: their next state is ready for the following request in the same cycle.
// Reset (rst_n low, asynchronous) returns the keyer to idle with an empty pipe.
// A stalled audio port fills the pipe's bubbles first, then holds off cmd.
module morse_tone_keyer (
    input  logic      clk,
    input  logic      rst_n,
    mtk_in_if.sink    cmd,
    mtk_out_if.source audio
);
    import mtk_pkg::*;

    // The sequencer owns the symbol state (phase, sample count, units left,
    // symbol kind) and turns each tick into a sample request: the table phase
    // and a ramp factor num/den.  Start commands only touch that state and
    // never enter the pipe, so they cannot reorder samples.
    logic      req_valid;
    tone_req_t req;
    logic      pipe_ready;

    mtk_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pipe_ready (pipe_ready),
        .req_valid  (req_valid),
        .req        (req)
    );

    // The shaper looks up the sine magnitude, scales it by the ramp factor and
    // rounds half away from zero.  The division by den * 2^16 is a shift and a
    // multiply by a reciprocal, followed by one compare-and-subtract fix-up.
    // Each stage moves independently, so a stalled output does not stall the
    // stages behind it while they still hold bubbles.
    mtk_shaper u_shaper (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req        (req),
        .pipe_ready (pipe_ready),
        .audio      (audio)
    );

endmodule

// ===== tb/sv/keyer_sample_checker.sv =====
`timescale 1ns / 1ps

module keyer_sample_checker (
    input  logic clk,
    input  logic rst_n,
    mtk_in_if    cmd,
    mtk_out_if   audio,
    output int   errors,
    output int   pending,
    output int   samples_checked,
    output int   tone_samples,
    output int   symbol_ends
);
    import mtk_pkg::*;

    typedef enum logic [1:0] {
        SYM_IDLE,
        SYM_DIT,
        SYM_DAH,
        SYM_SILENCE
    } symbol_kind_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       active;
        logic                       last;
    } audio_sample_t;

    audio_sample_t expected_samples[$];

    // Keyer state as the predictor tracks it.
    logic [PHASE_W-1:0] phase;
    logic [CNT_W-1:0]   unit_pos;
    logic [UNITS_W-1:0] units_left;
    symbol_kind_t       kind;

    // Tone magnitude (3200*sin, 16 fraction bits) and sign for each phase.
    logic [63:0] sine_mag [PERIOD_SAMPLES];
    bit          sine_neg [PERIOD_SAMPLES];

    // First quadrant sine with 30 fraction bits from a rounded Taylor series.
    function automatic logic [63:0] quarter_wave(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] d;
        longint      sum;
        x    = (64'(HALF_PI_Q30) * 64'(r) + 64'(PERIOD_SAMPLES / 2)) / 64'(PERIOD_SAMPLES);
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            d    = 64'(2 * n) * 64'(2 * n + 1);
            term = (term * x2 + (64'd1 << 29)) >> 30;
            term = (term + d / 2) / d;
            if (n % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30))
        begin
            sum = longint'(1) << 30;
        end
        return 64'(sum);
    endfunction

    initial
    begin
        int unsigned m;
        int unsigned q;
        int unsigned r;
        for (int unsigned p = 0; p < PERIOD_SAMPLES; p++)
        begin
            m = 4 * p;
            q = m / PERIOD_SAMPLES;
            r = m % PERIOD_SAMPLES;
            if (q % 2 == 1)
            begin
                r = PERIOD_SAMPLES - r;
            end
            sine_neg[p] = (q >= 2);
            sine_mag[p] = (quarter_wave(r) * 64'(AMPLITUDE) + (64'd1 << 13)) >> 14;
        end
    end

    // Applies one accepted command request to the tracked state and queues the
    // sample that a tick produces.
    task automatic advance_keyer(input action_t act, input logic [UNITS_W-1:0] count_in);
        audio_sample_t nxt;
        logic [63:0]   num;
        logic [63:0]   den;
        logic [63:0]   dd;
        logic [63:0]   v;
        bit            fade_in;
        bit            last_unit;
        if (act != ACT_TICK)
        begin
            // Starts are ignored while a symbol plays.
            if (kind == SYM_IDLE)
            begin
                phase    = '0;
                unit_pos = '0;
                if (act == ACT_DIT)
                begin
                    kind       = SYM_DIT;
                    units_left = UNITS_W'(1);
                end
                else if (act == ACT_DAH)
                begin
                    kind       = SYM_DAH;
                    units_left = UNITS_W'(3);
                end
                else if (count_in != 0)
                begin
                    kind       = SYM_SILENCE;
                    units_left = count_in;
                end
            end
        end
        else if (kind == SYM_IDLE)
        begin
            nxt.sample = '0;
            nxt.active = 1'b0;
            nxt.last   = 1'b0;
            expected_samples.push_back(nxt);
        end
        else
        begin
            nxt.sample = '0;
            if (kind != SYM_SILENCE)
            begin
                num       = 64'd1;
                den       = 64'd1;
                fade_in   = (kind == SYM_DIT) || (kind == SYM_DAH && units_left == 3);
                last_unit = (units_left == 1);
                if (fade_in && unit_pos < FADE_SAMPLES)
                begin
                    num = num * 64'(unit_pos);
                    den = den * 64'(FADE_SAMPLES);
                end
                if (last_unit && unit_pos + FADE_SAMPLES > UNIT_SAMPLES)
                begin
                    num = num * (64'(UNIT_SAMPLES) - 64'(unit_pos));
                    den = den * 64'(FADE_SAMPLES);
                end
                dd = den << 16;
                v  = (64'd2 * sine_mag[phase] * num + dd) / (64'd2 * dd);
                nxt.sample = SAMPLE_W'(sine_neg[phase] ? (64'd0 - v) : v);
            end
            nxt.active = 1'b1;
            nxt.last   = (units_left == 1) && (unit_pos + 1 >= UNIT_SAMPLES);
            expected_samples.push_back(nxt);

            phase    = (phase + 1 >= PERIOD_SAMPLES) ? '0 : phase + 1'b1;
            unit_pos = unit_pos + 1'b1;
            if (unit_pos >= UNIT_SAMPLES)
            begin
                unit_pos   = '0;
                phase      = '0;
                units_left = units_left - 1'b1;
                if (units_left == 0)
                begin
                    kind = SYM_IDLE;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        audio_sample_t want;
        if (!rst_n)
        begin
            phase           = '0;
            unit_pos        = '0;
            units_left      = '0;
            kind            = SYM_IDLE;
            errors          = 0;
            samples_checked = 0;
            tone_samples    = 0;
            symbol_ends     = 0;
            expected_samples.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                advance_keyer(action_t'(cmd.action), cmd.units);
            end
            if (audio.valid && audio.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t: unexpected audio sample %0d active %b last %b",
                                 $realtime, audio.sample, audio.active, audio.last);
                    end
                end
                else
                begin
                    want = expected_samples.pop_front();
                    samples_checked++;
                    if (want.active)
                    begin
                        tone_samples++;
                    end
                    if (want.last)
                    begin
                        symbol_ends++;
                    end
                    if (audio.sample !== want.sample || audio.active !== want.active ||
                        audio.last !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: audio sample %0d: expected %0d/%b/%b, got %0d/%b/%b",
                                     $realtime, samples_checked, want.sample, want.active,
                                     want.last, audio.sample, audio.active, audio.last);
                        end
                    end
                end
            end
        end
        pending = expected_samples.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mtk_pkg::*;

    logic clk;
    logic rst_n;

    // While set, neither the command side nor the audio side idles, which gives
    // stretches of back-to-back requests through the whole sample pipe.
    bit calm;

    int errors;
    int pending;
    int samples_checked;
    int tone_samples;
    int symbol_ends;
    int requests_sent;

    mtk_in_if  cmd_if ();
    mtk_out_if audio_if ();

    morse_tone_keyer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .audio (audio_if)
    );

    // The checker watches both channels, predicts every sample and counts
    // mismatches; this module drives requests, reset and audio back-pressure and decides the verdict.
    keyer_sample_checker sample_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_if),
        .audio           (audio_if),
        .errors          (errors),
        .pending         (pending),
        .samples_checked (samples_checked),
        .tone_samples    (tone_samples),
        .symbol_ends     (symbol_ends)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Idle stretches on either side are mostly short, now and then long.
    function automatic int pick_gap();
        if ($urandom_range(9) == 0)
        begin
            return $urandom_range(30, 8);
        end
        return $urandom_range(3, 1);
    endfunction

    // Presents one command request at a falling edge and returns at the falling
    // edge after it was accepted. Valid stays high on return, so the next call
    // either overwrites the payload or lowers valid for a gap, but never does
    // both in the same time step.
    task automatic send_cmd(input action_t act, input logic [UNITS_W-1:0] count_in);
        int gap;
        gap = (!calm && $urandom_range(99) < 10) ? pick_gap() : 0;
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.action <= act;
        cmd_if.units  <= count_in;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
        @(negedge clk);
    endtask

    // Sends n ticks with random filler in the unused units field. With noisy set,
    // the caller guarantees that a symbol still has at least n samples to play,
    // so a start slipped in before any of these ticks must be ignored.
    task automatic run_ticks(input int n, input bit noisy);
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(199) == 0)
            begin
                send_cmd(action_t'($urandom_range(3, 1)), UNITS_W'($urandom));
            end
            send_cmd(ACT_TICK, UNITS_W'($urandom));
        end
    endtask

    // Holds off the command side until the checker has seen every sample.
    // The loop waits for a falling edge before it checks, so valid is never lowered and raised in one step.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
    endtask

    // Audio back-pressure: random stalls unless a calm stretch is running.
    initial
    begin
        int stall_left;
        stall_left = 0;
        audio_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                audio_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                audio_if.ready <= 1'b1;
                if (!calm && $urandom_range(99) < 10)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial
    begin
        int wait_cycles;

        calm          = 1'b0;
        requests_sent = 0;
        rst_n         <= 1'b0;
        cmd_if.valid  <= 1'b0;
        cmd_if.action <= ACT_TICK;
        cmd_if.units  <= '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Ticks while idle must give silent, inactive samples, whatever the
        // units field holds.
        send_cmd(ACT_TICK, '0);
        send_cmd(ACT_TICK, '1);
        // A silence of zero units plays nothing and leaves the keyer idle.
        send_cmd(ACT_SILENCE, '0);
        send_cmd(ACT_TICK, 16'h5555);
        // A dit, with every kind of start offered while it plays; those starts
        // are dropped, and the dit still fades in and out over one unit.
        send_cmd(ACT_DIT, 16'hAAAA);
        send_cmd(ACT_DAH, '1);
        send_cmd(ACT_SILENCE, 16'hAAAA);
        send_cmd(ACT_DIT, 16'h5555);
        // The unit goes out in chunks, some of them with no idling on either side.
        for (int c = 0; c < 20; c++)
        begin
            calm = ($urandom_range(3) == 0);
            run_ticks(int'(UNIT_SAMPLES / 20), 1'b1);
        end
        calm = 1'b0;
        // An idle tick right behind the dit's last sample.
        send_cmd(ACT_TICK, '1);
        drain();

        // The opening of a dah: its first unit fades in, then holds full amplitude.
        send_cmd(ACT_DAH, '0);
        run_ticks(int'(FADE_SAMPLES) + 20, 1'b1);

        // Let the pipe empty, then keep watching the audio side for stray samples.
        cmd_if.valid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (20) @(negedge clk);

        if (pending != 0)
        begin
            $display("%0d expected samples never arrived", pending);
        end
        $display("Sent %0d command requests: idle ticks, an empty silence, a whole dit,",
                 requests_sent);
        $display("the start of a dah and stray starts; compared %0d samples, %0d inside %s %0d.",
                 samples_checked, tone_samples, "symbols, symbol ends seen:", symbol_ends);
        if (errors == 0 && pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Run timed out");
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== morse_tone_keyer.f =====
rtl/core/mtk_pkg.sv
rtl/core/mtk_in_if.sv
rtl/core/mtk_out_if.sv
rtl/core/mtk_seq.sv
rtl/core/mtk_shaper.sv
rtl/core/morse_tone_keyer.sv
tb/sv/keyer_sample_checker.sv
tb/sv/tb_top.sv
